// ----- design/assert_macros.svh -----
// Assertion macros shared by the line stepper RTL.
// Each macro checks a property on the rising edge of i_clk, held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_SYNC(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

// ----- design/lps_pkg.sv -----
// Shared types and constants for the line pixel stepper.
// Used by lps_front, lps_back and line_pixel_stepper_unit; no dependencies.
package lps_pkg;

    localparam int COORD_BITS = 12;
    localparam int ERR_BITS = COORD_BITS + 2;
    localparam int E2_BITS = ERR_BITS + 1;
    localparam int COLOR_BITS = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_BITS = 1;
    localparam int QUEUE_CNT_BITS = 2;

    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam int REG_BITS = 12;
    localparam logic [REG_BITS-1:0] SCREEN_WIDTH_RESET = 12'd320;
    localparam logic [REG_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd320;

    localparam logic REG_SCREEN_WIDTH = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_STEP = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [COORD_BITS-1:0]  x_start;
        logic [COORD_BITS-1:0]  y_start;
        logic [COORD_BITS-1:0]  x_end;
        logic [COORD_BITS-1:0]  y_end;
        logic [COLOR_BITS-1:0]  color;
    } t_cmd;

    typedef struct packed {
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  y;
        logic [COLOR_BITS-1:0]  color;
        logic                   visible;
        logic                   last;
    } t_point;

endpackage

// ----- design/line_pixel_stepper_unit.sv -----
// Top level of the line pixel stepper: configuration registers and the front/back pair.
// Depends on lps_pkg, lps_front and lps_back.
//
// Usage: items enter through a queue-style port (push/full). A load item
// (kind 0) sets up a line from start to end with a pen color and gives no
// result. Each step item (kind 1) on an active line gives one point with its
// color, a visible flag and a last flag; a step with no active line gives none.
// Results leave through a queue-style port (empty/pop); the oldest point is on
// the o_point_* ports while empty is low.
// A step waits in the command queue until the back part takes it, and its point
// is then written into the result queue. Throughput: one item per cycle while
// full stays low, set by the error update in the back part.
// A two-entry command queue separates the front from the back and a two-entry
// result queue follows the back; when pop stays low the result queue fills,
// then the command queue, then full rises. Loads still drain while results
// are stalled.
// Reset (i_rst_n low at a clock edge) empties both queues, drops the line and
// sets screen width and height to 320. The APB registers are screen width at
// address 0 and screen height at address 4.

module line_pixel_stepper_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_kind,
    input  logic [lps_pkg::COORD_BITS-1:0] i_x_start,
    input  logic [lps_pkg::COORD_BITS-1:0] i_y_start,
    input  logic [lps_pkg::COORD_BITS-1:0] i_x_end,
    input  logic [lps_pkg::COORD_BITS-1:0] i_y_end,
    input  logic [lps_pkg::COLOR_BITS-1:0] i_pen_color,
    output logic                           empty,
    input  logic                           pop,
    output logic [lps_pkg::COORD_BITS-1:0] o_point_x,
    output logic [lps_pkg::COORD_BITS-1:0] o_point_y,
    output logic [lps_pkg::COLOR_BITS-1:0] o_point_color,
    output logic                           o_visible,
    output logic                           o_last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lps_pkg::PADDR_BITS-1:0] paddr,
    input  logic [lps_pkg::PDATA_BITS-1:0] pwdata,
    output logic [lps_pkg::PDATA_BITS-1:0] prdata,
    output logic                           pready
);

    logic [lps_pkg::REG_BITS-1:0]   r_screen_width, n_screen_width;
    logic [lps_pkg::REG_BITS-1:0]   r_screen_height, n_screen_height;
    logic                           w_cfg_wr;
    logic                           w_reg_sel;
    lps_pkg::t_cmd                  w_cmd;
    logic                           w_cmd_valid;
    logic                           w_take;
    lps_pkg::t_point                w_point;

    assign pready = 1'b1;
    assign w_reg_sel = paddr[lps_pkg::PADDR_BITS-1];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_screen_width = r_screen_width;
        n_screen_height = r_screen_height;
        if (w_cfg_wr) begin
            case (w_reg_sel)
                lps_pkg::REG_SCREEN_WIDTH: begin
                    n_screen_width = pwdata[lps_pkg::REG_BITS-1:0];
                end
                lps_pkg::REG_SCREEN_HEIGHT: begin
                    n_screen_height = pwdata[lps_pkg::REG_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_sel)
            lps_pkg::REG_SCREEN_WIDTH: begin
                prdata = {{(lps_pkg::PDATA_BITS - lps_pkg::REG_BITS){1'b0}}, r_screen_width};
            end
            lps_pkg::REG_SCREEN_HEIGHT: begin
                prdata = {{(lps_pkg::PDATA_BITS - lps_pkg::REG_BITS){1'b0}}, r_screen_height};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width <= lps_pkg::SCREEN_WIDTH_RESET;
            r_screen_height <= lps_pkg::SCREEN_HEIGHT_RESET;
        end else begin
            r_screen_width <= n_screen_width;
            r_screen_height <= n_screen_height;
        end
    end

    lps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_kind      (i_kind),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .i_pen_color (i_pen_color),
        .i_take      (w_take),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid)
    );

    lps_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cmd_valid     (w_cmd_valid),
        .o_take          (w_take),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_point         (w_point)
    );

    assign o_point_x = w_point.x;
    assign o_point_y = w_point.y;
    assign o_point_color = w_point.color;
    assign o_visible = w_point.visible;
    assign o_last = w_point.last;

endmodule

// ----- design/lps_front.sv -----
// Front part of the line stepper: accepts items and classifies them as load or step.
// Holds them in a short command queue for lps_back. Depends on lps_pkg.
`include "assert_macros.svh"

module lps_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic                           i_kind,
    input  logic [lps_pkg::COORD_BITS-1:0] i_x_start,
    input  logic [lps_pkg::COORD_BITS-1:0] i_y_start,
    input  logic [lps_pkg::COORD_BITS-1:0] i_x_end,
    input  logic [lps_pkg::COORD_BITS-1:0] i_y_end,
    input  logic [lps_pkg::COLOR_BITS-1:0] i_pen_color,
    input  logic                           i_take,
    output lps_pkg::t_cmd                  o_cmd,
    output logic                           o_cmd_valid
);

    lps_pkg::t_cmd                          r_q [lps_pkg::QUEUE_DEPTH];
    logic [lps_pkg::QUEUE_PTR_BITS-1:0]     r_wr_ptr, n_wr_ptr;
    logic [lps_pkg::QUEUE_PTR_BITS-1:0]     r_rd_ptr, n_rd_ptr;
    logic [lps_pkg::QUEUE_CNT_BITS-1:0]     r_count, n_count;
    logic                                   w_wr;
    logic                                   w_rd;
    lps_pkg::t_cmd                          w_cmd_in;

    assign o_full = (r_count == lps_pkg::QUEUE_CNT_BITS'(lps_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd = r_q[r_rd_ptr];
    assign w_wr = i_push && !o_full;
    assign w_rd = i_take && o_cmd_valid;

    always_comb begin
        w_cmd_in.kind = lps_pkg::t_kind'(i_kind);
        w_cmd_in.x_start = i_x_start;
        w_cmd_in.y_start = i_y_start;
        w_cmd_in.x_end = i_x_end;
        w_cmd_in.y_end = i_y_end;
        w_cmd_in.color = i_pen_color;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == lps_pkg::QUEUE_PTR_BITS'(lps_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == lps_pkg::QUEUE_PTR_BITS'(lps_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= w_cmd_in;
        end
    end

    `ASSERT_SYNC(a_front_push_lands, w_wr && !w_rd |=> o_cmd_valid, "Accepted item lost in queue")
    `ASSERT_NEVER(a_front_take_empty, i_take && !o_cmd_valid && r_count != '0, "Queue count broken")

endmodule

// ----- design/lps_back.sv -----
// Back part of the line stepper: Bresenham state, error rule and the result queue.
// Executes commands from lps_front one per cycle while the result queue has room. Depends on lps_pkg.
`include "assert_macros.svh"

module lps_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lps_pkg::t_cmd                  i_cmd,
    input  logic                           i_cmd_valid,
    output logic                           o_take,
    input  logic [lps_pkg::REG_BITS-1:0]   i_screen_width,
    input  logic [lps_pkg::REG_BITS-1:0]   i_screen_height,
    input  logic                           i_pop,
    output logic                           o_empty,
    output lps_pkg::t_point                o_point
);

    logic [lps_pkg::COORD_BITS-1:0]         r_cur_x, n_cur_x;
    logic [lps_pkg::COORD_BITS-1:0]         r_cur_y, n_cur_y;
    logic [lps_pkg::COORD_BITS-1:0]         r_goal_x, n_goal_x;
    logic [lps_pkg::COORD_BITS-1:0]         r_goal_y, n_goal_y;
    logic [lps_pkg::COORD_BITS-1:0]         r_dist_x, n_dist_x;
    logic [lps_pkg::COORD_BITS-1:0]         r_dist_y, n_dist_y;
    logic                                   r_step_left, n_step_left;
    logic                                   r_step_up, n_step_up;
    logic signed [lps_pkg::ERR_BITS-1:0]    r_err, n_err;
    logic [lps_pkg::COLOR_BITS-1:0]         r_color, n_color;
    logic                                   r_active, n_active;

    lps_pkg::t_point                        r_q [lps_pkg::QUEUE_DEPTH];
    logic [lps_pkg::QUEUE_PTR_BITS-1:0]     r_wr_ptr, n_wr_ptr;
    logic [lps_pkg::QUEUE_PTR_BITS-1:0]     r_rd_ptr, n_rd_ptr;
    logic [lps_pkg::QUEUE_CNT_BITS-1:0]     r_count, n_count;

    logic                                   w_room;
    logic                                   w_load;
    logic                                   w_emit;
    logic                                   w_pop;
    logic                                   w_is_last;
    logic                                   w_move_x;
    logic                                   w_move_y;
    logic signed [lps_pkg::E2_BITS-1:0]     w_e2;
    logic signed [lps_pkg::E2_BITS-1:0]     w_dx;
    logic signed [lps_pkg::E2_BITS-1:0]     w_dy;
    logic signed [lps_pkg::ERR_BITS-1:0]    w_dx_e;
    logic signed [lps_pkg::ERR_BITS-1:0]    w_dy_e;
    logic signed [lps_pkg::ERR_BITS-1:0]    w_ldx;
    logic signed [lps_pkg::ERR_BITS-1:0]    w_ldy;
    lps_pkg::t_point                        w_point;

    assign o_empty = (r_count == '0);
    assign o_point = r_q[r_rd_ptr];
    assign w_pop = i_pop && !o_empty;
    assign w_room = (r_count != lps_pkg::QUEUE_CNT_BITS'(lps_pkg::QUEUE_DEPTH)) || w_pop;

    assign o_take = i_cmd_valid &&
                    ((i_cmd.kind == lps_pkg::KIND_LOAD) || !r_active || w_room);
    assign w_load = o_take && (i_cmd.kind == lps_pkg::KIND_LOAD);
    assign w_emit = o_take && (i_cmd.kind == lps_pkg::KIND_STEP) && r_active;

    assign w_is_last = (r_cur_x == r_goal_x) && (r_cur_y == r_goal_y);
    assign w_e2 = {r_err, 1'b0};
    assign w_dx = {{(lps_pkg::E2_BITS - lps_pkg::COORD_BITS){1'b0}}, r_dist_x};
    assign w_dy = {{(lps_pkg::E2_BITS - lps_pkg::COORD_BITS){1'b0}}, r_dist_y};
    assign w_dx_e = {{(lps_pkg::ERR_BITS - lps_pkg::COORD_BITS){1'b0}}, r_dist_x};
    assign w_dy_e = {{(lps_pkg::ERR_BITS - lps_pkg::COORD_BITS){1'b0}}, r_dist_y};
    assign w_move_x = (w_e2 > -w_dy);
    assign w_move_y = (w_e2 < w_dx);

    always_comb begin
        w_point.x = r_cur_x;
        w_point.y = r_cur_y;
        w_point.color = r_color;
        w_point.visible = (r_cur_x < i_screen_width) && (r_cur_y < i_screen_height);
        w_point.last = w_is_last;
    end

    always_comb begin
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_goal_x = r_goal_x;
        n_goal_y = r_goal_y;
        n_dist_x = r_dist_x;
        n_dist_y = r_dist_y;
        n_step_left = r_step_left;
        n_step_up = r_step_up;
        n_err = r_err;
        n_color = r_color;
        n_active = r_active;
        w_ldx = '0;
        w_ldy = '0;
        if (w_load) begin
            n_cur_x = i_cmd.x_start;
            n_cur_y = i_cmd.y_start;
            n_goal_x = i_cmd.x_end;
            n_goal_y = i_cmd.y_end;
            n_step_left = !(i_cmd.x_start < i_cmd.x_end);
            n_step_up = !(i_cmd.y_start < i_cmd.y_end);
            n_dist_x = n_step_left ? i_cmd.x_start - i_cmd.x_end
                                   : i_cmd.x_end - i_cmd.x_start;
            n_dist_y = n_step_up ? i_cmd.y_start - i_cmd.y_end
                                 : i_cmd.y_end - i_cmd.y_start;
            w_ldx = {{(lps_pkg::ERR_BITS - lps_pkg::COORD_BITS){1'b0}}, n_dist_x};
            w_ldy = {{(lps_pkg::ERR_BITS - lps_pkg::COORD_BITS){1'b0}}, n_dist_y};
            n_err = w_ldx - w_ldy;
            n_color = i_cmd.color;
            n_active = 1'b1;
        end else if (w_emit) begin
            if (w_is_last) begin
                n_active = 1'b0;
            end else begin
                n_err = r_err - (w_move_x ? w_dy_e : '0) + (w_move_y ? w_dx_e : '0);
                if (w_move_x) begin
                    n_cur_x = r_step_left ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                end
                if (w_move_y) begin
                    n_cur_y = r_step_up ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (w_emit) begin
            n_wr_ptr = (r_wr_ptr == lps_pkg::QUEUE_PTR_BITS'(lps_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == lps_pkg::QUEUE_PTR_BITS'(lps_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (w_emit && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_emit) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_dist_x <= '0;
            r_dist_y <= '0;
            r_step_left <= 1'b0;
            r_step_up <= 1'b0;
            r_err <= '0;
            r_color <= '0;
            r_active <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_goal_x <= n_goal_x;
            r_goal_y <= n_goal_y;
            r_dist_x <= n_dist_x;
            r_dist_y <= n_dist_y;
            r_step_left <= n_step_left;
            r_step_up <= n_step_up;
            r_err <= n_err;
            r_color <= n_color;
            r_active <= n_active;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_q[r_wr_ptr] <= w_point;
        end
    end

    `ASSERT_SYNC(a_back_step_moves, w_emit && !w_is_last |=> (r_cur_x != $past(r_cur_x) || r_cur_y != $past(r_cur_y)), "Step did not move the point")
    `ASSERT_SYNC(a_back_last_ends, w_emit && w_is_last |=> !r_active && !o_empty, "End point did not close the line")
    `ASSERT_NEVER(a_back_overflow, w_emit && !w_room, "Result queue overflow")

endmodule

// ----- bench/line_pixel_stepper_unit_test.sv -----
// Self-checking testbench for line_pixel_stepper_unit, the Bresenham line rasterizer.
// Depends on lps_pkg and the RTL; a tracer class predicts each point and checks the
// results, while plain tasks drive commands and register writes and a free-running process drives pops.
`timescale 1ns / 100ps

module line_pixel_stepper_unit_test;

    class line_tracer;
        lps_pkg::t_point pending[$];
        int mismatches;
        logic [lps_pkg::REG_BITS-1:0] screen_w, screen_h;
        logic [lps_pkg::COORD_BITS-1:0] cur_x, cur_y, goal_x, goal_y, dist_x, dist_y;
        logic step_left, step_up, active;
        logic signed [lps_pkg::ERR_BITS-1:0] err_term;
        logic [lps_pkg::COLOR_BITS-1:0] line_color;

        function new();
            mismatches = 0;
            screen_w = lps_pkg::SCREEN_WIDTH_RESET;
            screen_h = lps_pkg::SCREEN_HEIGHT_RESET;
            cur_x = '0;
            cur_y = '0;
            goal_x = '0;
            goal_y = '0;
            dist_x = '0;
            dist_y = '0;
            step_left = 1'b0;
            step_up = 1'b0;
            active = 1'b0;
            err_term = '0;
            line_color = '0;
        endfunction

        function void set_register(logic idx, logic [lps_pkg::REG_BITS-1:0] value);
            if (idx == lps_pkg::REG_SCREEN_WIDTH) begin
                screen_w = value;
            end else begin
                screen_h = value;
            end
        endfunction

        function void note_command(lps_pkg::t_cmd cmd);
            lps_pkg::t_point p;
            int e2;
            int err;
            if (cmd.kind == lps_pkg::KIND_LOAD) begin
                cur_x = cmd.x_start;
                cur_y = cmd.y_start;
                goal_x = cmd.x_end;
                goal_y = cmd.y_end;
                dist_x = (cmd.x_start > cmd.x_end) ? cmd.x_start - cmd.x_end
                                                   : cmd.x_end - cmd.x_start;
                dist_y = (cmd.y_start > cmd.y_end) ? cmd.y_start - cmd.y_end
                                                   : cmd.y_end - cmd.y_start;
                step_left = !(cmd.x_start < cmd.x_end);
                step_up = !(cmd.y_start < cmd.y_end);
                err = int'(dist_x) - int'(dist_y);
                err_term = err[lps_pkg::ERR_BITS-1:0];
                line_color = cmd.color;
                active = 1'b1;
                return;
            end
            if (!active) return;
            p.x = cur_x;
            p.y = cur_y;
            p.color = line_color;
            p.visible = (cur_x < screen_w) && (cur_y < screen_h);
            p.last = (cur_x == goal_x) && (cur_y == goal_y);
            pending.push_back(p);
            if (p.last) begin
                active = 1'b0;
                return;
            end
            err = int'(err_term);
            e2 = 2 * err;
            if (e2 > -int'(dist_y)) begin
                err = err - int'(dist_y);
                cur_x = step_left ? cur_x - 1'b1 : cur_x + 1'b1;
            end
            if (e2 < int'(dist_x)) begin
                err = err + int'(dist_x);
                cur_y = step_up ? cur_y - 1'b1 : cur_y + 1'b1;
            end
            err_term = err[lps_pkg::ERR_BITS-1:0];
        endfunction

        function void check_point(lps_pkg::t_point got);
            lps_pkg::t_point want;
            if (pending.size() == 0) begin
                $error("point (%0d, %0d) arrived with no step pending", got.x, got.y);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x) begin
                $error("point_x: expected %0d, got %0d", want.x, got.x);
                mismatches++;
            end
            if (got.y !== want.y) begin
                $error("point_y: expected %0d, got %0d", want.y, got.y);
                mismatches++;
            end
            if (got.color !== want.color) begin
                $error("point_color: expected %h, got %h", want.color, got.color);
                mismatches++;
            end
            if (got.visible !== want.visible) begin
                $error("visible: expected %0b, got %0b", want.visible, got.visible);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    logic i_kind;
    logic [lps_pkg::COORD_BITS-1:0] i_x_start, i_y_start, i_x_end, i_y_end;
    logic [lps_pkg::COLOR_BITS-1:0] i_pen_color;
    logic empty;
    logic pop;
    logic [lps_pkg::COORD_BITS-1:0] o_point_x, o_point_y;
    logic [lps_pkg::COLOR_BITS-1:0] o_point_color;
    logic o_visible, o_last;
    logic psel, penable, pwrite;
    logic [lps_pkg::PADDR_BITS-1:0] paddr;
    logic [lps_pkg::PDATA_BITS-1:0] pwdata, prdata;
    logic pready;

    line_tracer tracer = new();
    int send_idle_pct;
    int recv_idle_pct;
    int stall_left;
    int items_sent;
    lps_pkg::t_point seen_point;

    line_pixel_stepper_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_kind(i_kind), .i_x_start(i_x_start), .i_y_start(i_y_start),
        .i_x_end(i_x_end), .i_y_end(i_y_end), .i_pen_color(i_pen_color),
        .empty(empty), .pop(pop),
        .o_point_x(o_point_x), .o_point_y(o_point_y), .o_point_color(o_point_color),
        .o_visible(o_visible), .o_last(o_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            seen_point.x = o_point_x;
            seen_point.y = o_point_y;
            seen_point.color = o_point_color;
            seen_point.visible = o_visible;
            seen_point.last = o_last;
            tracer.check_point(seen_point);
        end
    end

    task automatic send_cmd(input lps_pkg::t_cmd cmd);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_kind <= cmd.kind;
        i_x_start <= cmd.x_start;
        i_y_start <= cmd.y_start;
        i_x_end <= cmd.x_end;
        i_y_end <= cmd.y_end;
        i_pen_color <= cmd.color;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        tracer.note_command(cmd);
        items_sent++;
    endtask

    // Step commands carry random values in the fields the block ignores.
    task automatic send_step();
        lps_pkg::t_cmd cmd;
        cmd.kind = lps_pkg::KIND_STEP;
        cmd.x_start = lps_pkg::COORD_BITS'($urandom);
        cmd.y_start = lps_pkg::COORD_BITS'($urandom);
        cmd.x_end = lps_pkg::COORD_BITS'($urandom);
        cmd.y_end = lps_pkg::COORD_BITS'($urandom);
        cmd.color = lps_pkg::COLOR_BITS'($urandom);
        send_cmd(cmd);
    endtask

    task automatic send_line(input logic [lps_pkg::COORD_BITS-1:0] xs,
                             input logic [lps_pkg::COORD_BITS-1:0] ys,
                             input logic [lps_pkg::COORD_BITS-1:0] xe,
                             input logic [lps_pkg::COORD_BITS-1:0] ye,
                             input logic [lps_pkg::COLOR_BITS-1:0] color, input int steps);
        lps_pkg::t_cmd cmd;
        cmd.kind = lps_pkg::KIND_LOAD;
        cmd.x_start = xs;
        cmd.y_start = ys;
        cmd.x_end = xe;
        cmd.y_end = ye;
        cmd.color = color;
        send_cmd(cmd);
        repeat (steps) send_step();
    endtask

    function automatic logic [lps_pkg::COORD_BITS-1:0] pick_coord();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return lps_pkg::COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [lps_pkg::COORD_BITS-1:0] near_coord(
        logic [lps_pkg::COORD_BITS-1:0] v);
        int t;
        t = int'(v) + int'($urandom_range(30)) - 15;
        if (t < 0) t = 0;
        if (t > (1 << lps_pkg::COORD_BITS) - 1) t = (1 << lps_pkg::COORD_BITS) - 1;
        return t[lps_pkg::COORD_BITS-1:0];
    endfunction

    // Most lines are short and run to their end; some stop early, overrun, or are
    // long lines that the next load cuts off.
    task automatic send_random_line();
        logic [lps_pkg::COORD_BITS-1:0] xs, ys, xe, ye;
        int dx, dy, steps, sel;
        xs = pick_coord();
        ys = pick_coord();
        if ($urandom_range(15) == 0) begin
            xe = pick_coord();
            ye = pick_coord();
        end else begin
            xe = near_coord(xs);
            ye = near_coord(ys);
        end
        dx = (xs > xe) ? int'(xs - xe) : int'(xe - xs);
        dy = (ys > ye) ? int'(ys - ye) : int'(ye - ys);
        steps = ((dx > dy) ? dx : dy) + 1;
        sel = $urandom_range(9);
        if (steps > 40) begin
            steps = $urandom_range(40, 1);
        end else if (sel == 0) begin
            steps = $urandom_range(steps - 1, 0);
        end else if (sel == 1) begin
            steps = steps + $urandom_range(3, 1);
        end
        send_line(xs, ys, xe, ye, lps_pkg::COLOR_BITS'($urandom), steps);
    endtask

    task automatic reg_write(input logic idx, input logic [lps_pkg::REG_BITS-1:0] value);
        logic [lps_pkg::PDATA_BITS-1:0] wdata;
        wdata = $urandom;
        if ($urandom_range(1)) wdata[lps_pkg::PDATA_BITS-1:lps_pkg::REG_BITS] = '0;
        wdata[lps_pkg::REG_BITS-1:0] = value;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= lps_pkg::PADDR_BITS'({idx, 2'b00});
        pwdata <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracer.set_register(idx, value);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {{(lps_pkg::PDATA_BITS-lps_pkg::REG_BITS){1'b0}}, value}) begin
            $error("register %0d: expected %h, got %h", idx, value, prdata);
            tracer.mismatches++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (tracer.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int phase;
        int target;
        logic [lps_pkg::REG_BITS-1:0] w, h;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_kind = lps_pkg::KIND_LOAD;
        i_x_start = '0;
        i_y_start = '0;
        i_x_end = '0;
        i_y_end = '0;
        i_pen_color = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 21;
        recv_idle_pct = 61;
        stall_left = 0;
        items_sent = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_step();
        send_line(12'd0, 12'd0, 12'd0, 12'd0, 16'h0000, 2);
        send_line(12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'hFFFF, 1);
        send_line(12'd0, 12'd4095, 12'd4095, 12'd0, 16'hA5A5, 2);
        send_line(12'd5, 12'd3, 12'd1, 12'd7, 16'h5A5A, 5);
        send_line(12'd4, 12'd2, 12'd3, 12'd5, 16'h07E0, 5);
        send_line(12'd318, 12'd321, 12'd321, 12'd319, 16'hF800, 4);

        for (phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: begin
                    w = '0;
                    h = '1;
                end
                1: begin
                    w = '1;
                    h = '0;
                end
                2: begin
                    w = '1;
                    h = '1;
                end
                default: begin
                    w = lps_pkg::REG_BITS'($urandom);
                    h = lps_pkg::REG_BITS'($urandom);
                end
            endcase
            reg_write(lps_pkg::REG_SCREEN_WIDTH, w);
            reg_write(lps_pkg::REG_SCREEN_HEIGHT, h);
            send_idle_pct = (phase < 2) ? 21 : (phase < 4) ? 61 : 0;
            recv_idle_pct = (phase < 2) ? 61 : (phase < 4) ? 21 : 0;
            if (phase == 4) stall_left = 300;
            target = items_sent + 200;
            while (items_sent < target) send_random_line();
        end
        drain();

        if (tracer.mismatches == 0 && tracer.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+design
design/lps_pkg.sv
design/lps_front.sv
design/lps_back.sv
design/line_pixel_stepper_unit.sv
bench/line_pixel_stepper_unit_test.sv
